### hdl/sts_pkg.sv
package sts_pkg;

	localparam int TIME_W = 32;
	localparam int KEY_W  = 34;
	localparam int TEXT_W = 16;
	localparam int LI_W   = 8;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_FIND   = 2'd2,
		CMD_LINE   = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_SEL,
		S_FIN
	} state_t;

	typedef struct packed {
		logic cmp;
		logic ins;
		logic find;
		logic line;
	} cell_ctl_t;

endpackage

### hdl/sts_cell.sv
module sts_cell #(
	parameter int IW = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sts_pkg::cell_ctl_t                  ctl,
	input  logic                                live,
	input  logic                                line_sel,
	input  logic [IW-1:0]                       index,
	input  logic signed [sts_pkg::KEY_W-1:0]    key,
	input  logic [sts_pkg::TIME_W-1:0]          new_time,
	input  logic [sts_pkg::TEXT_W-1:0]          new_text,
	input  logic                                prev_le,
	input  logic [sts_pkg::TIME_W-1:0]          prev_time,
	input  logic [sts_pkg::TEXT_W-1:0]          prev_text,
	input  logic                                next_le,
	output logic                                le,
	output logic [sts_pkg::TIME_W-1:0]          entry_time,
	output logic [sts_pkg::TEXT_W-1:0]          entry_text,
	output logic                                hit,
	output logic [sts_pkg::TIME_W-1:0]          hit_time,
	output logic [sts_pkg::TEXT_W-1:0]          hit_text,
	output logic [IW-1:0]                       hit_index
);

	logic                          le_q;
	logic [sts_pkg::TIME_W-1:0]    time_q;
	logic [sts_pkg::TEXT_W-1:0]    text_q;
	logic signed [sts_pkg::KEY_W-1:0] time_ext;

	assign time_ext = $signed({2'b00, time_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			le_q <= 1'b0;
		end else if (ctl.cmp) begin
			le_q <= live && (time_ext <= key);
		end
	end

	// entries above the insert point move up by one
	always_ff @(posedge clk) begin
		if (ctl.ins && !le_q) begin
			if (prev_le) begin
				time_q <= new_time;
				text_q <= new_text;
			end else begin
				time_q <= prev_time;
				text_q <= prev_text;
			end
		end
	end

	assign le         = le_q;
	assign entry_time = time_q;
	assign entry_text = text_q;
	assign hit        = (ctl.find && le_q && !next_le) || (ctl.line && live && line_sel);
	assign hit_time   = hit ? time_q : '0;
	assign hit_text   = hit ? text_q : '0;
	assign hit_index  = hit ? index : '0;

endmodule

### hdl/sorted_timestamp_table_core.sv
// Sorted table of up to ENTRIES timed lines held in a row of cells, one entry per
// cell, kept in ascending time order with equal times in arrival order. A
// transaction accepted by the slave side passes through the S_CMP, S_SEL and S_FIN
// states: in S_CMP all cells compare their time against the key at once, in S_SEL
// the matching cell is picked (or the row shifts for an insert), and in S_FIN the
// offset is added into the output register. The slave side is ready again in the
// cycle after that load, so a new transaction is taken only once the last result is
// in the output register; a result held back by a low m_tready holds the next
// transaction back as well. The user must write offset_ms on the cfg channel only
// while the table is idle; the block itself does not enforce this.
module sorted_timestamp_table_core #(
	parameter int ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,    // offset_ms
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,     // time_ms[31:0], text_ref[47:32], line_index[55:48]
	input  logic [1:0]  s_tuser,     // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,     // found_index[7:0], reported_time[41:8], found_text[57:42]
	output logic [1:0]  m_tuser      // status
);

	localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int LW    = (IW > sts_pkg::LI_W) ? IW : sts_pkg::LI_W;
	localparam int TW    = sts_pkg::TIME_W;
	localparam int XW    = sts_pkg::TEXT_W;
	localparam int KW    = sts_pkg::KEY_W;

	sts_pkg::state_t  state_q, state_d;
	sts_pkg::cmd_t    cmd_q;
	logic [CNT_W-1:0] count_q;
	logic signed [TW-1:0] offset_q;

	logic signed [KW-1:0] key_q;
	logic [TW-1:0]        tms_q;
	logic [XW-1:0]        text_q;
	logic [LW-1:0]        li_q;

	logic          sel_hit_q;
	logic          sel_full_q;
	logic [TW-1:0] sel_time_q;
	logic [XW-1:0] sel_text_q;
	logic [IW-1:0] sel_idx_q;

	logic                 out_valid_q;
	sts_pkg::status_t     out_status_q;
	logic [7:0]           out_index_q;
	logic signed [KW-1:0] out_time_q;
	logic [XW-1:0]        out_text_q;

	sts_pkg::cell_ctl_t ctl;
	logic               full;
	logic               in_acc;
	logic               fin_load;
	logic               do_sel;

	logic [ENTRIES-1:0] le_w, hit_w, live_w, lsel_w;
	logic [TW-1:0]      time_w  [ENTRIES];
	logic [XW-1:0]      text_w  [ENTRIES];
	logic [TW-1:0]      htime_w [ENTRIES];
	logic [XW-1:0]      htext_w [ENTRIES];
	logic [IW-1:0]      hidx_w  [ENTRIES];

	logic          red_hit;
	logic [TW-1:0] red_time;
	logic [XW-1:0] red_text;
	logic [IW-1:0] red_idx;
	logic [LW-1:0] red_idx_ext;

	logic signed [KW-1:0] sum;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == sts_pkg::S_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign full      = (count_q == CNT_W'(ENTRIES));
	assign fin_load  = (state_q == sts_pkg::S_FIN) && (!out_valid_q || m_tready);
	assign do_sel    = (state_q == sts_pkg::S_SEL);

	assign ctl.cmp  = (state_q == sts_pkg::S_CMP);
	assign ctl.ins  = do_sel && (cmd_q == sts_pkg::CMD_INSERT) && !full;
	assign ctl.find = (cmd_q == sts_pkg::CMD_FIND);
	assign ctl.line = (cmd_q == sts_pkg::CMD_LINE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sts_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sts_pkg::S_IDLE: if (in_acc)   state_d = sts_pkg::S_CMP;
			sts_pkg::S_CMP:                state_d = sts_pkg::S_SEL;
			sts_pkg::S_SEL:                state_d = sts_pkg::S_FIN;
			sts_pkg::S_FIN:  if (fin_load) state_d = sts_pkg::S_IDLE;
			default:                       state_d = sts_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			offset_q <= $signed(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= sts_pkg::CMD_CLEAR;
		end else if (in_acc) begin
			cmd_q <= sts_pkg::cmd_t'(s_tuser);
		end
	end

	// find key is query time minus offset, exact in the wider key; others use the time
	always_ff @(posedge clk) begin
		if (in_acc) begin
			tms_q  <= s_tdata[31:0];
			text_q <= s_tdata[47:32];
			li_q   <= LW'(s_tdata[55:48]);
			if (sts_pkg::cmd_t'(s_tuser) == sts_pkg::CMD_FIND) begin
				key_q <= $signed({2'b00, s_tdata[31:0]}) - KW'(offset_q);
			end else begin
				key_q <= $signed({2'b00, s_tdata[31:0]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_sel && (cmd_q == sts_pkg::CMD_CLEAR)) begin
			count_q <= '0;
		end else if (ctl.ins) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		logic          p_le;
		logic [TW-1:0] p_time;
		logic [XW-1:0] p_text;
		logic          n_le;

		assign live_w[g] = (CNT_W'(g) < count_q);
		assign lsel_w[g] = (LW'(g) == li_q);

		if (g == 0) begin : g_first
			assign p_le   = 1'b1;
			assign p_time = '0;
			assign p_text = '0;
		end else begin : g_mid
			assign p_le   = le_w[g-1];
			assign p_time = time_w[g-1];
			assign p_text = text_w[g-1];
		end

		if (g == ENTRIES - 1) begin : g_last
			assign n_le = 1'b0;
		end else begin : g_inner
			assign n_le = le_w[g+1];
		end

		sts_cell #(
			.IW(IW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.live      (live_w[g]),
			.line_sel  (lsel_w[g]),
			.index     (IW'(g)),
			.key       (key_q),
			.new_time  (tms_q),
			.new_text  (text_q),
			.prev_le   (p_le),
			.prev_time (p_time),
			.prev_text (p_text),
			.next_le   (n_le),
			.le        (le_w[g]),
			.entry_time(time_w[g]),
			.entry_text(text_w[g]),
			.hit       (hit_w[g]),
			.hit_time  (htime_w[g]),
			.hit_text  (htext_w[g]),
			.hit_index (hidx_w[g])
		);
	end

	// at most one cell hits, so an or over the row picks it
	always_comb begin
		red_time = '0;
		red_text = '0;
		red_idx  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			red_time = red_time | htime_w[i];
			red_text = red_text | htext_w[i];
			red_idx  = red_idx  | hidx_w[i];
		end
		red_hit = |hit_w;
	end

	// full is taken before the insert moves the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_hit_q  <= 1'b0;
			sel_full_q <= 1'b0;
		end else if (do_sel) begin
			sel_hit_q  <= red_hit;
			sel_full_q <= full;
		end
	end

	always_ff @(posedge clk) begin
		if (do_sel) begin
			sel_time_q <= red_time;
			sel_text_q <= red_text;
			sel_idx_q  <= red_idx;
		end
	end

	assign red_idx_ext = LW'(sel_idx_q);
	assign sum         = $signed({2'b00, sel_time_q}) + KW'(offset_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			case (cmd_q)
				sts_pkg::CMD_INSERT: begin
					out_status_q <= sel_full_q ? sts_pkg::ST_FULL : sts_pkg::ST_OK;
					out_index_q  <= '0;
					out_time_q   <= '0;
					out_text_q   <= '0;
				end
				sts_pkg::CMD_FIND, sts_pkg::CMD_LINE: begin
					if (sel_hit_q) begin
						out_status_q <= sts_pkg::ST_OK;
						out_index_q  <= red_idx_ext[7:0];
						out_time_q   <= sum;
						out_text_q   <= sel_text_q;
					end else begin
						out_status_q <= sts_pkg::ST_MISS;
						out_index_q  <= '0;
						out_time_q   <= '0;
						out_text_q   <= '0;
					end
				end
				default: begin
					out_status_q <= sts_pkg::ST_OK;
					out_index_q  <= '0;
					out_time_q   <= '0;
					out_text_q   <= '0;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {6'b000000, out_text_q, out_time_q, out_index_q};

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count beyond table size");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == sts_pkg::ST_MISS) |-> (m_tdata == '0))
		else $error("miss result carries data");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (s_tuser == sts_pkg::CMD_CLEAR) |=> ##2 (count_q == '0))
		else $error("clear left entries in table");

	a_full_no_grow: assert property (@(posedge clk) disable iff (!arst_n)
		do_sel && (cmd_q == sts_pkg::CMD_INSERT) && full |=> $stable(count_q))
		else $error("insert into full table changed count");

endmodule

### tb/tb_sorted_timestamp_table_core.sv
module tb_sorted_timestamp_table_core;

	localparam int ENTRIES     = 256;
	localparam int LATENCY     = 4;
	localparam int IDLE_PCT    = 21;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		sts_pkg::status_t          status;
		logic [7:0]                index;
		logic [sts_pkg::KEY_W-1:0] rep_time;
		logic [15:0]               text;
	} table_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;

	// expected table contents and offset
	logic [31:0]        tbl_times [ENTRIES];
	logic [15:0]        tbl_texts [ENTRIES];
	int unsigned        tbl_count;
	logic signed [31:0] tbl_offset;

	table_result_t pending_results[$];
	table_result_t want;
	int unsigned   fail_count;
	int unsigned   quiet_cycles;
	bit            steady;

	sorted_timestamp_table_core #(
		.ENTRIES(ENTRIES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// number of stored entries with time at or below t
	function automatic int unsigned count_not_after(logic signed [63:0] t);
		int unsigned n;
		n = 0;
		for (int unsigned k = 0; k < tbl_count; k++)
			if ($signed({32'd0, tbl_times[k]}) <= t)
				n = k + 1;
		return n;
	endfunction

	function automatic table_result_t entry_hit(int unsigned i);
		table_result_t r;
		logic signed [63:0] sum;
		sum = $signed({32'd0, tbl_times[i]}) + $signed({{32{tbl_offset[31]}}, tbl_offset});
		r.status = sts_pkg::ST_OK;
		r.index = i[7:0];
		r.rep_time = sum[sts_pkg::KEY_W-1:0];
		r.text = tbl_texts[i];
		return r;
	endfunction

	function automatic table_result_t apply_command(sts_pkg::cmd_t cmd, logic [31:0] tms,
			logic [15:0] txt, logic [7:0] li);
		table_result_t r;
		int unsigned pos;
		logic signed [63:0] q;
		r = '0;
		case (cmd)
			sts_pkg::CMD_CLEAR: begin
				tbl_count = 0;
			end
			sts_pkg::CMD_INSERT: begin
				if (tbl_count >= ENTRIES) begin
					r.status = sts_pkg::ST_FULL;
				end else begin
					pos = count_not_after($signed({32'd0, tms}));
					for (int unsigned k = tbl_count; k > pos; k--) begin
						tbl_times[k] = tbl_times[k-1];
						tbl_texts[k] = tbl_texts[k-1];
					end
					tbl_times[pos] = tms;
					tbl_texts[pos] = txt;
					tbl_count++;
				end
			end
			sts_pkg::CMD_FIND: begin
				q = $signed({32'd0, tms}) - $signed({{32{tbl_offset[31]}}, tbl_offset});
				if (tbl_count == 0 || q < $signed({32'd0, tbl_times[0]}))
					r.status = sts_pkg::ST_MISS;
				else
					r = entry_hit(count_not_after(q) - 1);
			end
			default: begin
				if (li >= tbl_count)
					r.status = sts_pkg::ST_MISS;
				else
					r = entry_hit(li);
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
		$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
		fail_count++;
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_item(sts_pkg::cmd_t cmd, logic [31:0] tms, logic [15:0] txt,
			logic [7:0] li);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = cmd;
		s_tdata = {li, txt, tms};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(apply_command(cmd, tms, txt, li));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	task automatic write_offset(logic signed [31:0] value);
		wait_drained();
		cfg_valid = 1'b1;
		cfg_data = value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tbl_offset = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_basics();
		send_item(sts_pkg::CMD_FIND, 32'd0, 16'h0000, 8'd0);
		send_item(sts_pkg::CMD_LINE, 32'd0, 16'h0000, 8'd0);
		send_item(sts_pkg::CMD_INSERT, 32'd100, 16'h0001, 8'd0);
		send_item(sts_pkg::CMD_INSERT, 32'd0, 16'h0000, 8'hff);
		send_item(sts_pkg::CMD_INSERT, 32'hffff_ffff, 16'hffff, 8'd0);
		// equal times keep arrival order
		send_item(sts_pkg::CMD_INSERT, 32'd100, 16'h0002, 8'd0);
		send_item(sts_pkg::CMD_INSERT, 32'd100, 16'h0003, 8'd0);
		send_item(sts_pkg::CMD_FIND, 32'd100, 16'h0000, 8'd0);
		send_item(sts_pkg::CMD_FIND, 32'd99, 16'h0000, 8'd0);
		send_item(sts_pkg::CMD_FIND, 32'hffff_ffff, 16'h0000, 8'd0);
		send_item(sts_pkg::CMD_LINE, 32'd0, 16'h0000, 8'd4);
		send_item(sts_pkg::CMD_LINE, 32'd0, 16'h0000, 8'd5);
		send_item(sts_pkg::CMD_LINE, 32'hffff_ffff, 16'hffff, 8'hff);
		send_item(sts_pkg::CMD_CLEAR, 32'hffff_ffff, 16'hffff, 8'hff);
		send_item(sts_pkg::CMD_FIND, 32'd100, 16'h0000, 8'd0);
		send_item(sts_pkg::CMD_INSERT, 32'd500, 16'h1234, 8'd0);
		// query below the first entry
		send_item(sts_pkg::CMD_FIND, 32'd499, 16'h0000, 8'd0);
	endtask

	task automatic test_offset_extremes();
		write_offset(32'sd1000);
		send_item(sts_pkg::CMD_FIND, 32'd1499, 16'h0000, 8'd0);
		send_item(sts_pkg::CMD_FIND, 32'd1500, 16'h0000, 8'd0);
		write_offset(32'sh8000_0000);
		send_item(sts_pkg::CMD_FIND, 32'd0, 16'h0000, 8'd0);
		send_item(sts_pkg::CMD_LINE, 32'd0, 16'h0000, 8'd0);
		write_offset(32'sh7fff_ffff);
		send_item(sts_pkg::CMD_INSERT, 32'hffff_ffff, 16'hbeef, 8'd0);
		send_item(sts_pkg::CMD_LINE, 32'd0, 16'h0000, 8'd1);
		// negative query time
		send_item(sts_pkg::CMD_FIND, 32'd0, 16'h0000, 8'd0);
		write_offset(32'sd0);
	endtask

	task automatic test_full_table();
		send_item(sts_pkg::CMD_CLEAR, 32'd0, 16'h0000, 8'd0);
		repeat (ENTRIES)
			send_item(sts_pkg::CMD_INSERT, 32'($urandom_range(300)), 16'($urandom),
				8'($urandom));
		send_item(sts_pkg::CMD_INSERT, 32'd0, 16'h5555, 8'd0);
		send_item(sts_pkg::CMD_INSERT, 32'hffff_ffff, 16'haaaa, 8'd0);
		send_item(sts_pkg::CMD_LINE, 32'd0, 16'h0000, 8'hff);
		send_item(sts_pkg::CMD_FIND, 32'hffff_ffff, 16'h0000, 8'd0);
		send_item(sts_pkg::CMD_FIND, 32'd150, 16'h0000, 8'd0);
		send_item(sts_pkg::CMD_CLEAR, 32'd0, 16'h0000, 8'd0);
		send_item(sts_pkg::CMD_LINE, 32'd0, 16'h0000, 8'd0);
	endtask

	task automatic test_random(int unsigned per_phase);
		logic [31:0]        tms;
		logic [7:0]         li;
		logic signed [31:0] off;
		sts_pkg::cmd_t      cmd;
		int unsigned        roll;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: off = 32'sd0;
				1: off = 32'sh8000_0000;
				2: off = 32'sh7fff_ffff;
				3: off = $urandom_range(5000) - 2500;
				default: off = $urandom;
			endcase
			write_offset(off);
			// one phase runs with no idling on either side
			steady = (phase == 3);
			repeat (per_phase) begin
				roll = $urandom_range(99);
				cmd = (roll < 2) ? sts_pkg::CMD_CLEAR : (roll < 47) ? sts_pkg::CMD_INSERT :
					(roll < 77) ? sts_pkg::CMD_FIND : sts_pkg::CMD_LINE;
				roll = $urandom_range(99);
				if (roll < 40 && tbl_count != 0) begin
					tms = tbl_times[$urandom_range(tbl_count - 1)] + $urandom_range(2) - 1;
					if (cmd == sts_pkg::CMD_FIND)
						tms = tms + tbl_offset;
				end else if (roll < 70) begin
					tms = $urandom_range(1000);
				end else begin
					tms = $urandom;
				end
				if ($urandom_range(99) < 80)
					li = 8'($urandom_range(tbl_count > 255 ? 255 : tbl_count));
				else
					li = 8'($urandom);
				send_item(cmd, tms, 16'($urandom), li);
			end
		end
		steady = 1'b0;
	endtask

	always @(negedge clk)
		m_tready = steady || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, 64'd0);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status)
					report_mismatch("status", 64'(m_tuser), 64'(want.status));
				if (m_tdata[7:0] !== want.index)
					report_mismatch("found_index", 64'(m_tdata[7:0]), 64'(want.index));
				if (m_tdata[41:8] !== want.rep_time)
					report_mismatch("reported_time", 64'(m_tdata[41:8]),
						64'(want.rep_time));
				if (m_tdata[57:42] !== want.text)
					report_mismatch("found_text", 64'(m_tdata[57:42]), 64'(want.text));
			end
		end
	end

	// no transaction on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = sts_pkg::CMD_CLEAR;
		m_tready = 1'b0;
		steady = 1'b0;
		fail_count = 0;
		quiet_cycles = 0;
		tbl_count = 0;
		tbl_offset = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_basics();
		test_offset_extremes();
		test_full_table();
		test_random(50);

		wait_drained();
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
